### rtl/core/lruts_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruts_pkg
// shared types, sizes and lookup tables of the timestamp lru replacement unit
// ----------------------------------------------------------------------------
package lruts_pkg;

   localparam int WAYS       = 4;
   localparam int SETS       = 256;
   localparam int TAG_BITS   = 20;
   localparam int STAMP_BITS = 64;

   localparam int WAY_BITS  = (WAYS > 1) ? $clog2(WAYS) : 1;
   localparam int SET_BITS  = (SETS > 1) ? $clog2(SETS) : 1;
   localparam int LINE_BITS = STAMP_BITS + 1 + TAG_BITS;
   localparam int ROW_BITS  = WAYS * LINE_BITS;
   localparam int VALID_OFS = STAMP_BITS;
   localparam int TAG_OFS   = STAMP_BITS + 1;
   localparam bit SCAN_NEEDED = (WAYS > 1);

   localparam int REQ_SET_VALUES = 256;
   localparam int REQ_WAY_VALUES = 4;

   typedef struct packed {
      logic        op;
      logic [7:0]  set_index;
      logic [1:0]  hit_way;
      logic [19:0] tag;
   } req_type;

   typedef struct packed {
      logic [1:0]  way;
      logic [63:0] stamp;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_LOAD,
      ST_SCAN,
      ST_WRITE
   } state_type;

   typedef struct packed {
      logic clear_row;
      logic accept;
      logic load;
      logic scan_step;
      logic commit;
   } cmd_type;

   typedef struct packed {
      logic clear_last;
      logic scan_last;
      logic op_miss;
   } sts_type;

   typedef logic [REQ_SET_VALUES-1:0][SET_BITS-1:0] set_map_type;
   typedef logic [REQ_WAY_VALUES-1:0][WAY_BITS-1:0] way_map_type;

   function automatic set_map_type build_set_map();
      set_map_type m;
      for (int i = 0; i < REQ_SET_VALUES; i++) begin
         m[i] = SET_BITS'(i % SETS);
      end
      return m;
   endfunction

   function automatic way_map_type build_way_map();
      way_map_type m;
      for (int i = 0; i < REQ_WAY_VALUES; i++) begin
         m[i] = WAY_BITS'(i % WAYS);
      end
      return m;
   endfunction

   localparam set_map_type SET_MAP = build_set_map();
   localparam way_map_type WAY_MAP = build_way_map();

endpackage
`default_nettype wire

### rtl/core/lruts_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruts_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module lruts_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  wire logic                                     clock,
   input  wire logic                                     wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                         wr_data,
   input  wire logic                                     rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output logic      [WIDTH-1:0]                         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

### rtl/core/lruts_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruts_ctrl
// sequencer: clearing pass, set read, victim scan and write back
// ----------------------------------------------------------------------------
module lruts_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              start,
   input  wire lruts_pkg::sts_type sts,
   output lruts_pkg::cmd_type     cmd,
   output logic                   busy
);

   lruts_pkg::state_type state_ff;
   lruts_pkg::state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lruts_pkg::ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      busy     = 1'b1;
      case (state_ff)
         lruts_pkg::ST_CLEAR: begin
            cmd.clear_row = 1'b1;
            if (sts.clear_last) begin
               state_in = lruts_pkg::ST_IDLE;
            end
         end
         lruts_pkg::ST_IDLE: begin
            busy = 1'b0;
            if (start) begin
               cmd.accept = 1'b1;
               state_in   = lruts_pkg::ST_LOAD;
            end
         end
         lruts_pkg::ST_LOAD: begin
            cmd.load = 1'b1;
            if (sts.op_miss && lruts_pkg::SCAN_NEEDED) begin
               state_in = lruts_pkg::ST_SCAN;
            end else begin
               state_in = lruts_pkg::ST_WRITE;
            end
         end
         lruts_pkg::ST_SCAN: begin
            cmd.scan_step = 1'b1;
            if (sts.scan_last) begin
               state_in = lruts_pkg::ST_WRITE;
            end
         end
         lruts_pkg::ST_WRITE: begin
            cmd.commit = 1'b1;
            state_in   = lruts_pkg::ST_IDLE;
         end
         default: begin
            state_in = lruts_pkg::ST_IDLE;
         end
      endcase
   end

endmodule
`default_nettype wire

### rtl/core/lruts_dp.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lruts_dp
// datapath: set row ram, age counter, victim compare and row update
// ----------------------------------------------------------------------------
module lruts_dp (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire lruts_pkg::cmd_type cmd,
   input  wire lruts_pkg::req_type req,
   output lruts_pkg::sts_type      sts,
   output logic                    rsp_strobe,
   output lruts_pkg::rsp_type      rsp_data
);

   logic [lruts_pkg::SET_BITS-1:0]   clr_ff;
   logic [lruts_pkg::SET_BITS-1:0]   clr_in;
   logic                             op_ff;
   logic [lruts_pkg::SET_BITS-1:0]   set_ff;
   logic [lruts_pkg::TAG_BITS-1:0]   tag_ff;
   logic [lruts_pkg::WAY_BITS-1:0]   way_ff;
   logic [lruts_pkg::WAY_BITS-1:0]   way_in;
   logic [lruts_pkg::WAY_BITS-1:0]   scan_ff;
   logic [lruts_pkg::STAMP_BITS-1:0] best_ff;
   logic [lruts_pkg::STAMP_BITS-1:0] best_in;
   logic [lruts_pkg::STAMP_BITS-1:0] age_ff;
   logic [lruts_pkg::STAMP_BITS-1:0] age_in;
   logic [lruts_pkg::ROW_BITS-1:0]   row_ff;
   logic [lruts_pkg::ROW_BITS-1:0]   row_in;
   logic                             rsp_strobe_ff;
   lruts_pkg::rsp_type               rsp_data_ff;

   logic [lruts_pkg::ROW_BITS-1:0]   rd_data;
   logic                             wr_en;
   logic [lruts_pkg::SET_BITS-1:0]   wr_addr;
   logic [lruts_pkg::ROW_BITS-1:0]   wr_data;
   logic [lruts_pkg::STAMP_BITS-1:0] cand;
   logic [lruts_pkg::LINE_BITS-1:0]  line_old;
   logic [lruts_pkg::LINE_BITS-1:0]  line_new;

   lruts_ram #(
      .WIDTH (lruts_pkg::ROW_BITS),
      .DEPTH (lruts_pkg::SETS)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (cmd.accept),
      .rd_addr (lruts_pkg::SET_MAP[req.set_index]),
      .rd_data (rd_data)
   );

   assign clr_in = clr_ff + lruts_pkg::SET_BITS'(1);
   assign age_in = age_ff + lruts_pkg::STAMP_BITS'(1);
   assign cand   = row_ff[scan_ff * lruts_pkg::LINE_BITS +: lruts_pkg::STAMP_BITS];

   always_comb begin
      best_in = best_ff;
      way_in  = way_ff;
      if (cand < best_ff) begin
         best_in = cand;
         way_in  = scan_ff;
      end
   end

   // replace the touched line inside the set row
   always_comb begin
      line_old = row_ff[way_ff * lruts_pkg::LINE_BITS +: lruts_pkg::LINE_BITS];
      line_new = line_old;
      line_new[lruts_pkg::STAMP_BITS-1:0] = age_in;
      if (op_ff) begin
         line_new[lruts_pkg::VALID_OFS] = 1'b1;
         line_new[lruts_pkg::TAG_OFS +: lruts_pkg::TAG_BITS] = tag_ff;
      end
      row_in = row_ff;
      row_in[way_ff * lruts_pkg::LINE_BITS +: lruts_pkg::LINE_BITS] = line_new;
   end

   always_comb begin
      wr_en   = cmd.clear_row | cmd.commit;
      wr_addr = cmd.clear_row ? clr_ff : set_ff;
      wr_data = cmd.clear_row ? '0 : row_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff        <= '0;
         age_ff        <= '0;
         rsp_strobe_ff <= 1'b0;
      end else begin
         rsp_strobe_ff <= cmd.commit;
         if (cmd.clear_row) begin
            clr_ff <= clr_in;
         end
         if (cmd.commit) begin
            age_ff <= age_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         op_ff  <= req.op;
         set_ff <= lruts_pkg::SET_MAP[req.set_index];
         tag_ff <= lruts_pkg::TAG_BITS'(req.tag);
         way_ff <= lruts_pkg::WAY_MAP[req.hit_way];
      end
      if (cmd.load) begin
         row_ff  <= rd_data;
         best_ff <= rd_data[lruts_pkg::STAMP_BITS-1:0];
         scan_ff <= lruts_pkg::WAY_BITS'(1);
         if (op_ff) begin
            way_ff <= '0;
         end
      end
      if (cmd.scan_step) begin
         best_ff <= best_in;
         way_ff  <= way_in;
         scan_ff <= scan_ff + lruts_pkg::WAY_BITS'(1);
      end
      if (cmd.commit) begin
         rsp_data_ff.way   <= 2'(way_ff);
         rsp_data_ff.stamp <= age_in;
      end
   end

   assign sts.clear_last = (clr_ff == lruts_pkg::SET_BITS'(lruts_pkg::SETS - 1));
   assign sts.scan_last  = (scan_ff == lruts_pkg::WAY_BITS'(lruts_pkg::WAYS - 1));
   assign sts.op_miss    = op_ff;

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_data   = rsp_data_ff;

endmodule
`default_nettype wire

### rtl/core/lru_timestamp_replacement_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lru_timestamp_replacement_unit
// timestamp based lru way selection and line stamping for a set-assoc cache
// ----------------------------------------------------------------------------
// usage:
//   drive req_data and raise start; the item is taken at a clock edge with
//   start high and busy low. op 0 stamps the named way, op 1 scans the set
//   for the oldest stamp (lowest way on a tie), fills tag and valid there
//   and stamps it.
//   one result per item appears on rsp_data for a single cycle with
//   rsp_strobe high; the receiver cannot stall, so nothing is held back.
//   rsp_strobe is registered from the write back; between the accepting
//   edge and the result lie one set row read that also seeds way 0 as the
//   best stamp, compare steps over ways 1 to WAYS - 1 on a miss only, one
//   write back and the result cycle.
//   busy is low again in the strobe cycle, so the next item can be taken
//   at its end; busy stays high while an item is in flight.
//   after reset the unit runs a clearing pass over all SETS rows (256) of the
//   set row ram with busy high; stamps, valid bits and the age counter all
//   start at zero.
// ----------------------------------------------------------------------------
module lru_timestamp_replacement_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire lruts_pkg::req_type req_data,
   output logic                    busy,
   output logic                    rsp_strobe,
   output lruts_pkg::rsp_type      rsp_data
);

   lruts_pkg::cmd_type cmd;
   lruts_pkg::sts_type sts;

   lruts_ctrl u_ctrl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .sts   (sts),
      .cmd   (cmd),
      .busy  (busy)
   );

   lruts_dp u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .req        (req_data),
      .sts        (sts),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

endmodule
`default_nettype wire

### tb/lru_timestamp_replacement_unit_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_timestamp_replacement_unit_test
// drives hit touches and miss fills into the timestamp lru unit, keeps its own
// per-line stamp table and age counter, and checks every way and stamp that
// comes back, in order, against that table
// ----------------------------------------------------------------------------
module lru_timestamp_replacement_unit_test;

   import lruts_pkg::*;

   localparam logic OP_HIT  = 1'b0;
   localparam logic OP_MISS = 1'b1;

   localparam int unsigned CYCLE_LIMIT   = 200000;
   localparam int unsigned RANDOM_ITEMS  = 1100;
   localparam int unsigned POOL_SETS     = 8;

   logic    clock;
   logic    reset;
   logic    start;
   req_type req_data;
   logic    busy;
   logic    rsp_strobe;
   rsp_type rsp_data;

   logic [63:0] line_age [SETS][WAYS];
   logic [63:0] age_now;
   rsp_type     stamped_lines [$];

   int unsigned failures;
   int unsigned cycle_count;
   bit          idle_enabled;

   lru_timestamp_replacement_unit dut (
      .clock      (clock),
      .reset      (reset),
      .start      (start),
      .req_data   (req_data),
      .busy       (busy),
      .rsp_strobe (rsp_strobe),
      .rsp_data   (rsp_data)
   );

   initial clock = 1'b0;
   always #1 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("lru_timestamp_replacement_unit_test NOT OK");
         $finish;
      end
   end

   // picks the line, bumps the age and stamps it
   function automatic rsp_type stamp_line(input req_type item);
      int          s;
      int          w;
      logic [63:0] best;
      rsp_type     r;
      s = int'(item.set_index) % SETS;
      if (item.op == OP_HIT) begin
         w = int'(item.hit_way) % WAYS;
      end else begin
         w = 0;
         best = line_age[s][0];
         for (int i = 1; i < WAYS; i++) begin
            if (line_age[s][i] < best) begin
               best = line_age[s][i];
               w = i;
            end
         end
      end
      age_now = age_now + 64'd1;
      line_age[s][w] = age_now;
      r.way = 2'(w);
      r.stamp = age_now;
      return r;
   endfunction

   function automatic req_type make_req(input logic op, input logic [7:0] set_index,
                                        input logic [1:0] hit_way, input logic [19:0] tag);
      req_type r;
      r.op = op;
      r.set_index = set_index;
      r.hit_way = hit_way;
      r.tag = tag;
      return r;
   endfunction

   function automatic req_type random_req();
      return make_req(1'($urandom_range(0, 1)), 8'($urandom_range(0, 255)),
                      2'($urandom_range(0, 3)), 20'($urandom_range(0, 20'hFFFFF)));
   endfunction

   task automatic send_item(input req_type item);
      start <= 1'b1;
      req_data <= item;
      @(posedge clock);
      while (busy) @(posedge clock);
      stamped_lines.push_back(stamp_line(item));
      while (idle_enabled && $urandom_range(0, 99) < 36) begin
         start <= 1'b0;
         req_data <= random_req();
         @(posedge clock);
      end
   endtask

   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_strobe) begin
         if (stamped_lines.size() == 0) begin
            $error("rsp_strobe with no item outstanding: way %0d stamp %0d",
                   rsp_data.way, rsp_data.stamp);
            failures++;
         end else begin
            want = stamped_lines.pop_front();
            if (rsp_data.way !== want.way) begin
               $error("way expected %0d actual %0d", want.way, rsp_data.way);
               failures++;
            end
            if (rsp_data.stamp !== want.stamp) begin
               $error("stamp expected %0d actual %0d", want.stamp, rsp_data.stamp);
               failures++;
            end
         end
      end
   end

   // empty set fills ways in order, then the oldest is evicted
   task automatic test_fill_order();
      send_item(make_req(OP_MISS, 8'h00, 2'd3, 20'h00000));
      send_item(make_req(OP_MISS, 8'h00, 2'd0, 20'hFFFFF));
      send_item(make_req(OP_MISS, 8'h00, 2'd1, 20'h12345));
      send_item(make_req(OP_MISS, 8'h00, 2'd2, 20'hABCDE));
      send_item(make_req(OP_MISS, 8'h00, 2'd3, 20'hFFFFF));
   endtask

   // hits on every way, then a miss takes the least recently touched
   task automatic test_hit_touch();
      send_item(make_req(OP_HIT, 8'hFF, 2'd0, 20'hFFFFF));
      send_item(make_req(OP_HIT, 8'hFF, 2'd1, 20'h00000));
      send_item(make_req(OP_HIT, 8'hFF, 2'd2, 20'hFFFFF));
      send_item(make_req(OP_HIT, 8'hFF, 2'd3, 20'h00000));
      send_item(make_req(OP_HIT, 8'hFF, 2'd0, 20'h55555));
      send_item(make_req(OP_MISS, 8'hFF, 2'd0, 20'hAAAAA));
   endtask

   // unused lines win ties at the lowest way, then the oldest stamp goes
   task automatic test_tie_break();
      send_item(make_req(OP_HIT, 8'hA5, 2'd2, 20'h0F0F0));
      send_item(make_req(OP_HIT, 8'hA5, 2'd0, 20'hF0F0F));
      send_item(make_req(OP_MISS, 8'hA5, 2'd3, 20'h00001));
      send_item(make_req(OP_MISS, 8'hA5, 2'd1, 20'h80000));
      send_item(make_req(OP_MISS, 8'hA5, 2'd2, 20'h7FFFF));
   endtask

   // mostly a few hot sets so victims come from well-aged rows
   task automatic test_random_traffic();
      logic [7:0] pool [POOL_SETS];
      req_type    item;
      for (int i = 0; i < POOL_SETS; i++) begin
         pool[i] = 8'($urandom_range(0, 255));
      end
      for (int unsigned n = 0; n < RANDOM_ITEMS; n++) begin
         idle_enabled = !(n >= 350 && n < 650);
         item = random_req();
         if ($urandom_range(0, 99) < 75) begin
            item.set_index = pool[$urandom_range(0, POOL_SETS - 1)];
         end
         send_item(item);
      end
      idle_enabled = 1'b1;
   endtask

   initial begin
      failures = 0;
      cycle_count = 0;
      idle_enabled = 1'b1;
      age_now = '0;
      for (int s = 0; s < SETS; s++) begin
         for (int w = 0; w < WAYS; w++) begin
            line_age[s][w] = '0;
         end
      end
      reset = 1'b1;
      start = 1'b0;
      req_data = '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_fill_order();
      test_hit_touch();
      test_tie_break();
      test_random_traffic();

      start <= 1'b0;
      while (stamped_lines.size() != 0) @(posedge clock);
      repeat (16) @(posedge clock);
      if (failures == 0) begin
         $display("lru_timestamp_replacement_unit_test OK");
      end else begin
         $display("lru_timestamp_replacement_unit_test NOT OK");
      end
      $finish;
   end

endmodule
